[rtl/core/gtp_pkg.sv]
// Shared types and constants for the Goertzel tone power unit.
package gtp_pkg;

   // Fixed field widths
   localparam int SAMPLE_BITS = 12;
   localparam int COEF_BITS   = 16;
   localparam int POWER_BITS  = 62;

   // Shared multiplier consumes one 16-bit digit of its second operand per cycle
   localparam int DIGIT_BITS  = 16;

   // Defaults for the top-level parameters
   localparam int COEFF_FRAC_BITS_DEFAULT = 14;
   localparam int SUM_BITS_DEFAULT        = 32;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COEF_MUL,
      ST_ROUND,
      ST_UPDATE,
      ST_SQ_LAST_LOAD,
      ST_SQ_LAST_STEP,
      ST_POWER_LOAD,
      ST_SQ_OLDER_LOAD,
      ST_SQ_OLDER_STEP,
      ST_POWER_ADD,
      ST_CROSS_LOAD,
      ST_CROSS_STEP,
      ST_DIFF,
      ST_FINISH
   } gtp_state_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_COEF_MUL,
      OP_ROUND,
      OP_UPDATE,
      OP_MUL_LOAD,
      OP_MUL_STEP,
      OP_POWER_LOAD,
      OP_POWER_ADD,
      OP_DIFF,
      OP_FINISH
   } gtp_op_type;

   // Multiplicand select for the shared multiplier
   typedef enum logic [1:0] {
      SRC_LAST,
      SRC_OLDER,
      SRC_PROD
   } gtp_src_type;

   typedef struct packed {
      gtp_op_type  op;
      gtp_src_type src;
   } gtp_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic rsp_free;
   } gtp_status_type;

endpackage

[rtl/core/gtp_channel_ifs.sv]
// Valid/ready channel interfaces for sample beats and power result beats.
interface gtp_req_if import gtp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface gtp_rsp_if import gtp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [POWER_BITS-1:0] tone_power;
   logic                  saturated;

   modport source (output valid, output tone_power, output saturated, input ready);
   modport sink   (input valid, input tone_power, input saturated, output ready);
endinterface

[rtl/core/gtp_controller.sv]
// Sequencer for the Goertzel unit: steps the datapath through update and power phases.
module gtp_controller import gtp_pkg::*; #(
   parameter int SUM_BITS = SUM_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  gtp_status_type status,
   output gtp_cmd_type    cmd
);

   localparam int ND  = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DCW = (ND > 1) ? $clog2(ND) : 1;
   localparam logic [DCW-1:0] LAST_DIGIT = DCW'(ND - 1);

   gtp_state_type  state_ff, state_in;
   logic [DCW-1:0] digit_ff, digit_in;

   // State and digit counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         digit_ff <= '0;
      end else begin
         state_ff <= state_in;
         digit_ff <= digit_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      digit_in = digit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_COEF_MUL;
         end
         ST_COEF_MUL: state_in = ST_ROUND;
         ST_ROUND:    state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = status.frame_end ? ST_SQ_LAST_LOAD : ST_IDLE;
         end
         ST_SQ_LAST_LOAD: begin
            digit_in = '0;
            state_in = ST_SQ_LAST_STEP;
         end
         ST_SQ_LAST_STEP: begin
            digit_in = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) state_in = ST_POWER_LOAD;
         end
         ST_POWER_LOAD: state_in = ST_SQ_OLDER_LOAD;
         ST_SQ_OLDER_LOAD: begin
            digit_in = '0;
            state_in = ST_SQ_OLDER_STEP;
         end
         ST_SQ_OLDER_STEP: begin
            digit_in = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) state_in = ST_POWER_ADD;
         end
         ST_POWER_ADD: state_in = ST_CROSS_LOAD;
         ST_CROSS_LOAD: begin
            digit_in = '0;
            state_in = ST_CROSS_STEP;
         end
         ST_CROSS_STEP: begin
            digit_in = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_FINISH;
         ST_FINISH: begin
            // hold until the result register can take the new beat
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.src   = SRC_LAST;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_CAPTURE;
         end
         ST_COEF_MUL:      cmd.op = OP_COEF_MUL;
         ST_ROUND:         cmd.op = OP_ROUND;
         ST_UPDATE:        cmd.op = OP_UPDATE;
         ST_SQ_LAST_LOAD:  cmd.op = OP_MUL_LOAD;
         ST_SQ_LAST_STEP:  cmd.op = OP_MUL_STEP;
         ST_POWER_LOAD:    cmd.op = OP_POWER_LOAD;
         ST_SQ_OLDER_LOAD: begin
            cmd.op  = OP_MUL_LOAD;
            cmd.src = SRC_OLDER;
         end
         ST_SQ_OLDER_STEP: begin
            cmd.op  = OP_MUL_STEP;
            cmd.src = SRC_OLDER;
         end
         ST_POWER_ADD:     cmd.op = OP_POWER_ADD;
         ST_CROSS_LOAD: begin
            cmd.op  = OP_MUL_LOAD;
            cmd.src = SRC_PROD;
         end
         ST_CROSS_STEP: begin
            cmd.op  = OP_MUL_STEP;
            cmd.src = SRC_PROD;
         end
         ST_DIFF:          cmd.op = OP_DIFF;
         ST_FINISH: begin
            if (status.rsp_free) cmd.op = OP_FINISH;
         end
         default:          cmd.op = OP_NONE;
      endcase
   end

endmodule

[rtl/core/gtp_datapath.sv]
// Goertzel datapath: filter sums, shared digit-serial multiplier, power and saturation.
module gtp_datapath import gtp_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT,
   parameter int SUM_BITS        = SUM_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gtp_cmd_type                   cmd,
   output gtp_status_type                status,
   input  logic                          csr_write_enable,
   input  logic signed [COEF_BITS-1:0]   csr_write_data,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [POWER_BITS-1:0]         rsp_tone_power,
   output logic                          rsp_saturated
);

   localparam int CW   = COEF_BITS;
   localparam int DW   = DIGIT_BITS;
   localparam int ND   = (SUM_BITS + DW - 1) / DW;
   localparam int MW   = ND * DW;              // multiplier operand, whole digits
   localparam int AW   = SUM_BITS + CW;        // multiplicand width
   localparam int ACCW = AW + MW;              // accumulator width
   localparam int TW   = AW + 1;               // rounded feedback term
   localparam int UW   = TW + 2;               // unsaturated new sum
   localparam int PW   = 2 * SUM_BITS;         // s1^2 + s2^2
   localparam int QW   = 2 * SUM_BITS + CW;    // |coeff*s1*s2|
   localparam int XW   = (COEFF_FRAC_BITS > CW) ? COEFF_FRAC_BITS : CW;
   localparam int DFA  = 2 * SUM_BITS + XW + 2;
   localparam int DFB  = POWER_BITS + XW + 2;
   localparam int DFW  = (DFA > DFB) ? DFA : DFB;

   localparam logic signed [TW:0]   HALF_T  = {{TW{1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
   localparam logic [DFW-1:0]       HALF_D  = {{(DFW-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
   localparam logic signed [UW-1:0] SUM_MAX = {{(UW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [UW-1:0] SUM_MIN = ~SUM_MAX;

   // Registers
   logic signed [CW-1:0]          coef_ff, coef_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          frame_end_ff, frame_end_in;
   logic signed [SUM_BITS-1:0]    last_ff, last_in;
   logic signed [SUM_BITS-1:0]    older_ff, older_in;
   logic                          clip_ff, clip_in;
   logic [ACCW-1:0]               acc_ff, acc_in;
   logic [MW-1:0]                 mop_ff, mop_in;
   logic                          sign_ff, sign_in;
   logic [AW-1:0]                 prod_ff, prod_in;
   logic signed [TW-1:0]          term_ff, term_in;
   logic [PW-1:0]                 power_ff, power_in;
   logic [DFW-1:0]                diff_ff, diff_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [POWER_BITS-1:0]         rsp_power_ff, rsp_power_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   // Combinational helpers
   logic [SUM_BITS-1:0]    mag_last, mag_older;
   logic [CW-1:0]          mag_coef;
   logic [AW-1:0]          mul_a;
   logic [DW-1:0]          mul_b;
   logic [AW+DW-1:0]       mul_p;
   logic signed [TW:0]     prod_signed, prod_rounded;
   logic signed [UW-1:0]   sum_wide;
   logic                   cross_neg;
   logic [DFW-1:0]         p_shift, q_ext;
   logic [DFW-1:0]         rnd, res_shift;
   logic                   pow_over;

   // Magnitudes of the signed operands
   assign mag_last  = last_ff[SUM_BITS-1]  ? -last_ff  : last_ff;
   assign mag_older = older_ff[SUM_BITS-1] ? -older_ff : older_ff;
   assign mag_coef  = coef_ff[CW-1]        ? -coef_ff  : coef_ff;

   // Shared multiplier: one multiplicand times one 16-bit digit
   always_comb begin
      case (cmd.src)
         SRC_OLDER: mul_a = AW'(mag_older);
         SRC_PROD:  mul_a = prod_ff;
         default:   mul_a = AW'(mag_last);
      endcase
      mul_b = (cmd.op == OP_COEF_MUL) ? mag_coef : mop_ff[MW-1 -: DW];
   end
   assign mul_p = AW'(mul_a) * (AW+DW)'(mul_b);

   // Rounded feedback term, new sum, and power pieces
   always_comb begin
      prod_signed  = $signed({2'b00, acc_ff[AW-1:0]});
      if (sign_ff) prod_signed = -prod_signed;
      prod_rounded = (prod_signed + HALF_T) >>> COEFF_FRAC_BITS;
      sum_wide     = UW'(sample_ff) + UW'(term_ff) - UW'(older_ff);
      cross_neg    = coef_ff[CW-1] ^ last_ff[SUM_BITS-1] ^ older_ff[SUM_BITS-1];
      p_shift      = DFW'(power_ff) << COEFF_FRAC_BITS;
      q_ext        = DFW'(acc_ff[QW-1:0]);
      rnd          = diff_ff + HALF_D;
      res_shift    = rnd >> COEFF_FRAC_BITS;
      pow_over     = |res_shift[DFW-1:POWER_BITS];
   end

   // Next-state logic per command
   always_comb begin
      coef_in      = csr_write_enable ? csr_write_data : coef_ff;
      sample_in    = sample_ff;
      frame_end_in = frame_end_ff;
      last_in      = last_ff;
      older_in     = older_ff;
      clip_in      = clip_ff;
      acc_in       = acc_ff;
      mop_in       = mop_ff;
      sign_in      = sign_ff;
      prod_in      = prod_ff;
      term_in      = term_ff;
      power_in     = power_ff;
      diff_in      = diff_ff;
      rsp_power_in = rsp_power_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (cmd.op)
         OP_CAPTURE: begin
            sample_in    = req_sample;
            frame_end_in = req_frame_end;
         end
         OP_COEF_MUL: begin
            acc_in  = ACCW'(mul_p);
            sign_in = coef_ff[CW-1] ^ last_ff[SUM_BITS-1];
         end
         OP_ROUND: begin
            // keep |coeff*s1| for the cross term: s1 becomes s2 on update
            prod_in = acc_ff[AW-1:0];
            term_in = prod_rounded[TW-1:0];
         end
         OP_UPDATE: begin
            older_in = last_ff;
            if (sum_wide > SUM_MAX) begin
               last_in = SUM_MAX[SUM_BITS-1:0];
               clip_in = 1'b1;
            end else if (sum_wide < SUM_MIN) begin
               last_in = SUM_MIN[SUM_BITS-1:0];
               clip_in = 1'b1;
            end else begin
               last_in = sum_wide[SUM_BITS-1:0];
            end
         end
         OP_MUL_LOAD: begin
            acc_in = '0;
            mop_in = (cmd.src == SRC_OLDER) ? MW'(mag_older) : MW'(mag_last);
         end
         OP_MUL_STEP: begin
            acc_in = (acc_ff << DW) + ACCW'(mul_p);
            mop_in = mop_ff << DW;
         end
         OP_POWER_LOAD: power_in = acc_ff[PW-1:0];
         OP_POWER_ADD:  power_in = power_ff + acc_ff[PW-1:0];
         OP_DIFF: begin
            diff_in = cross_neg ? (p_shift + q_ext) : (p_shift - q_ext);
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            if (diff_ff[DFW-1]) begin
               // negative power reads zero
               rsp_power_in = '0;
               rsp_sat_in   = 1'b1;
            end else if (pow_over) begin
               rsp_power_in = '1;
               rsp_sat_in   = 1'b1;
            end else begin
               rsp_power_in = res_shift[POWER_BITS-1:0];
               rsp_sat_in   = clip_ff;
            end
            last_in  = '0;
            older_in = '0;
            clip_in  = 1'b0;
         end
         default: ;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= '0;
         last_ff      <= '0;
         older_ff     <= '0;
         clip_ff      <= 1'b0;
         frame_end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         last_ff      <= last_in;
         older_ff     <= older_in;
         clip_ff      <= clip_in;
         frame_end_ff <= frame_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      acc_ff       <= acc_in;
      mop_ff       <= mop_in;
      sign_ff      <= sign_in;
      prod_ff      <= prod_in;
      term_ff      <= term_in;
      power_ff     <= power_in;
      diff_ff      <= diff_in;
      rsp_power_ff <= rsp_power_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign status.frame_end = frame_end_ff;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone_power   = rsp_power_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

[rtl/core/goertzel_tone_power_unit.sv]
// Goertzel tone power unit top level: controller, datapath and channel hookup.
// Each sample beat passes accept, coefficient multiply, round and sum update before the next.
// A frame-end sample then squares both sums and forms the cross term, and the power
// terms run through one shared multiplicand-by-16-bit-digit multiplier, one digit per cycle.
// The result beat is registered; sampling continues while it waits, up to the next frame end.
// Synchronous active-high reset clears the sums, clip flag, coefficient and result valid.
module goertzel_tone_power_unit import gtp_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT,
   parameter int SUM_BITS        = SUM_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   gtp_req_if.sink                     req_chan,
   gtp_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic signed [COEF_BITS-1:0] csr_write_data
);

   gtp_cmd_type    cmd;
   gtp_status_type status;
   logic           ready;

   // Sequencer
   gtp_controller #(
      .SUM_BITS (SUM_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = ready;

   // Arithmetic and result register
   gtp_datapath #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
      .SUM_BITS        (SUM_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_chan.sample),
      .req_frame_end    (req_chan.frame_end),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_tone_power   (rsp_chan.tone_power),
      .rsp_saturated    (rsp_chan.saturated)
   );

endmodule

[tb/sv/gtp_power_checker.sv]
// Beat monitor for the Goertzel tone power unit: predicts tone power per frame and compares.
`timescale 1ns / 100ps

module gtp_power_checker import gtp_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT,
   parameter int SUM_BITS        = SUM_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   gtp_req_if                          req_mon,
   gtp_rsp_if                          rsp_mon,
   input  logic                        csr_write_enable,
   input  logic signed [COEF_BITS-1:0] csr_write_data,
   output int                          fault_count,
   output int                          outstanding
);

   typedef struct packed {
      logic [POWER_BITS-1:0] tone_power;
      logic                  saturated;
   } power_beat_type;

   // Expected power beats, oldest first
   power_beat_type expected_powers[$];

   // Shadow copy of the filter state and the coefficient register
   logic signed [COEF_BITS-1:0] tone_coef;
   longint                      last_sum;
   longint                      older_sum;
   logic                        clip_flag;

   initial begin
      fault_count = 0;
      outstanding = 0;
      tone_coef   = '0;
      last_sum    = 0;
      older_sum   = 0;
      clip_flag   = 1'b0;
   end

   // One recurrence step; on a frame end also the power beat and a state clear
   task automatic advance_goertzel(input logic signed [SAMPLE_BITS-1:0] x, input logic last);
      longint              top;
      longint              bot;
      longint              prod;
      longint              next_sum;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] c;
      logic signed [127:0] diff;
      logic signed [127:0] pmax;
      power_beat_type      beat;
      top      = (longint'(1) <<< (SUM_BITS - 1)) - 1;
      bot      = -top - 1;
      prod     = longint'(tone_coef) * last_sum + (longint'(1) <<< (COEFF_FRAC_BITS - 1));
      next_sum = longint'(x) + (prod >>> COEFF_FRAC_BITS) - older_sum;
      if (next_sum > top) begin
         next_sum  = top;
         clip_flag = 1'b1;
      end else if (next_sum < bot) begin
         next_sum  = bot;
         clip_flag = 1'b1;
      end
      older_sum = last_sum;
      last_sum  = next_sum;
      if (last) begin
         // exact power, scaled by 2^F, then rounded half up
         a    = last_sum;
         b    = older_sum;
         c    = tone_coef;
         diff = ((a * a + b * b) <<< COEFF_FRAC_BITS) - c * a * b;
         pmax = (128'sd1 <<< POWER_BITS) - 128'sd1;
         if (diff < 0) begin
            clip_flag = 1'b1;
            diff      = '0;
         end else begin
            diff = (diff + (128'sd1 <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
            if (diff > pmax) begin
               clip_flag = 1'b1;
               diff      = pmax;
            end
         end
         beat.tone_power = diff[POWER_BITS-1:0];
         beat.saturated  = clip_flag;
         expected_powers.push_back(beat);
         last_sum  = 0;
         older_sum = 0;
         clip_flag = 1'b0;
      end
   endtask

   // Watch both channels and the register port at every rising edge
   always @(posedge clock) begin
      power_beat_type want;
      if (reset) begin
         tone_coef = '0;
         last_sum  = 0;
         older_sum = 0;
         clip_flag = 1'b0;
         expected_powers.delete();
      end else begin
         if (csr_write_enable) begin
            tone_coef = csr_write_data;
         end
         // result side first, so a stray beat never pairs with a fresh expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_powers.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected power beat: power %0d saturated %0b",
                           rsp_mon.tone_power, rsp_mon.saturated);
               end
            end else begin
               want = expected_powers.pop_front();
               if (rsp_mon.tone_power !== want.tone_power ||
                   rsp_mon.saturated !== want.saturated) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display({"power beat mismatch: expected power %0d saturated %0b,",
                               " got power %0d saturated %0b"},
                              want.tone_power, want.saturated,
                              rsp_mon.tone_power, rsp_mon.saturated);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_goertzel(req_mon.sample, req_mon.frame_end);
         end
      end
      outstanding = expected_powers.size();
   end

endmodule

[tb/sv/tb_goertzel_tone_power_unit.sv]
// Top-level bench for the Goertzel tone power unit: clock, reset, sample stimulus and verdict.
`timescale 1ns / 100ps

module tb_goertzel_tone_power_unit;
   import gtp_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 12'sd2047;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = -12'sd2048;
   localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 16'sd32767;
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = -16'sd32768;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_BEATS   = 32;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_write_enable;
   logic signed [COEF_BITS-1:0] csr_write_data;
   int                          fault_count;
   int                          outstanding;
   int                          beats_taken;
   bit                          calm;

   gtp_req_if req_bus ();
   gtp_rsp_if rsp_bus ();

   goertzel_tone_power_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   gtp_power_checker power_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fault_count      (fault_count),
      .outstanding      (outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop if the run hangs
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one sample beat after a random gap, return at the negedge after acceptance
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample    <= value;
      req_bus.frame_end <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Drain all expected beats, let in-flight samples finish, then load a new coefficient
   task automatic retune(input logic signed [COEF_BITS-1:0] coef);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= coef;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly full-range samples, with extremes and near-zero values mixed in
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         return SAMPLE_BITS'($urandom_range(0, 4095));
      end else if (kind == 6) begin
         return SAMPLE_MAX;
      end else if (kind == 7) begin
         return SAMPLE_MIN;
      end
      return SAMPLE_BITS'(int'($urandom_range(0, 32)) - 16);
   endfunction

   // Random frames until the beat budget is used; always ends on a frame end
   task automatic random_frames(input int budget);
      int sent;
      int frame_len;
      sent = 0;
      while (sent < budget) begin
         frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 60)
                                                 : $urandom_range(1, 20);
         for (int i = 0; i < frame_len; i++) begin
            send_sample(pick_sample(), i == frame_len - 1);
         end
         sent += frame_len;
      end
   endtask

   // Result side: random stall per beat, two long hold-offs to back up the input
   initial begin
      int unsigned gap;
      rsp_bus.ready = 1'b0;
      beats_taken   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 7);
         if (beats_taken == 10 || beats_taken == 24) begin
            gap = 600;
         end
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         beats_taken++;
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic signed [COEF_BITS-1:0] coef_list[8];
      int                          guard;
      reset             = 1'b1;
      calm              = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.sample    = '0;
      req_bus.frame_end = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: one-sample frames at both extremes, with the coefficient still at reset
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);

      // directed: zero frame, full-swing frame, then a tone right on the detector bin
      retune(16'sd23170);
      send_sample('0, 1'b0);
      send_sample('0, 1'b0);
      send_sample('0, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(12'sd1, 1'b0);
      send_sample(-12'sd1, 1'b1);
      send_sample(12'sd2047, 1'b0);
      send_sample(12'sd1447, 1'b0);
      send_sample(12'sd0, 1'b0);
      send_sample(-12'sd1447, 1'b0);
      send_sample(-12'sd2048, 1'b0);
      send_sample(-12'sd1448, 1'b0);
      send_sample(12'sd0, 1'b0);
      send_sample(12'sd1447, 1'b1);

      // directed: coefficient at both extremes
      retune(COEF_MAX);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      retune(COEF_MIN);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);

      // random frames across several tunings
      coef_list[0] = '0;
      coef_list[1] = COEF_MAX;
      coef_list[2] = COEF_MIN;
      coef_list[3] = -16'sd23170;
      coef_list[4] = 16'sd8481;
      coef_list[5] = COEF_BITS'($urandom_range(0, 65535));
      coef_list[6] = COEF_BITS'($urandom_range(0, 65535));
      coef_list[7] = 16'sd16384;
      for (int p = 0; p < 8; p++) begin
         retune(coef_list[p]);
         calm = (p == 3 || p == 6);
         random_frames(PHASE_BEATS);
      end

      // resonance at coefficient -2: alternating full-scale input drives both sums into clipping
      retune(COEF_MIN);
      calm = 1'b1;
      for (int i = 0; i < 1460; i++) begin
         send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
      end
      // retuned mid-frame to 0 so the clipped sums push the power past its ceiling
      retune('0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      calm = 1'b0;
      send_sample(pick_sample(), 1'b1);

      retune(COEF_BITS'($urandom_range(0, 65535)));
      random_frames(30);

      // drain and decide
      req_bus.valid <= 1'b0;
      guard = 0;
      while (outstanding != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
